// ----- src/mrh_pkg.sv -----
// ----------------------------------------------------------------------------
// mrh_pkg
// Shared types and constants of the maximal rectangle histogram scan.
// ----------------------------------------------------------------------------
`default_nettype none

package mrh_pkg;

    // Configuration register
    localparam int unsigned CFG_W     = 9;
    localparam int unsigned CFG_RESET = 256;

    // Result field
    localparam int unsigned     AREA_W     = 17;
    localparam logic [AREA_W-1:0] AREA_LIMIT = 17'h1FFFF;

    // Stream word widths
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 24;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_WALK,
        S_DRAIN
    } t_state;

    // Column store control
    typedef struct packed {
        logic wr_en;
        logic clear;
    } t_mem_ctl;

    // Area unit control and status
    typedef struct packed {
        logic cand;
        logic clear;
    } t_area_ctl;

    typedef struct packed {
        logic busy;
    } t_area_sts;

endpackage

`default_nettype wire

// ----- src/mrh_col_mem.sv -----
// ----------------------------------------------------------------------------
// mrh_col_mem
// Column store: one write and one registered read per cycle, write-first on
// a same-address collision, and one valid bit per entry, all cleared together.
// ----------------------------------------------------------------------------
`default_nettype none

module mrh_col_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8,
    parameter int unsigned DW    = 28
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  mrh_pkg::t_mem_ctl   i_ctl,
    input  wire  [AW-1:0]       i_wr_addr,
    input  wire  [DW-1:0]       i_wr_data,
    input  wire  [AW-1:0]       i_rd_addr,
    output logic [DW-1:0]       o_rd_data,
    output logic                o_rd_valid
);
    import mrh_pkg::*;

    logic [DW-1:0]    r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_valid;
    logic             w_collide;

    assign w_collide = i_ctl.wr_en && (i_wr_addr == i_rd_addr);

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, forward the word being written to the same entry
    always_ff @(posedge i_clk) begin
        if (w_collide) begin
            r_rd_data <= i_wr_data;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Valid bits: drop all on clear, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= w_collide || r_valid[i_rd_addr];
            if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

endmodule

`default_nettype wire

// ----- src/mrh_area_unit.sv -----
// ----------------------------------------------------------------------------
// mrh_area_unit
// Area pipeline: register width and height, multiply, saturate and keep the
// running maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module mrh_area_unit #(
    parameter int unsigned NW = 9,
    parameter int unsigned HW = 9
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  mrh_pkg::t_area_ctl          i_ctl,
    input  wire  [NW-1:0]               i_width,
    input  wire  [HW-1:0]               i_height,
    output mrh_pkg::t_area_sts          o_sts,
    output logic [mrh_pkg::AREA_W-1:0]  o_best
);
    import mrh_pkg::*;

    localparam int unsigned PW = NW + HW;

    logic              r_v1;
    logic              r_v2;
    logic [NW-1:0]     r_w;
    logic [HW-1:0]     r_h;
    logic [PW-1:0]     r_prod;
    logic [AREA_W-1:0] r_best;
    logic [AREA_W-1:0] w_sat;
    logic [AREA_W-1:0] n_best;

    // Stage valids and best value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_best <= '0;
        end else begin
            r_v1   <= i_ctl.cand;
            r_v2   <= r_v1;
            r_best <= n_best;
        end
    end

    // Operand and product registers
    always_ff @(posedge i_clk) begin
        r_w    <= i_width;
        r_h    <= i_height;
        r_prod <= {{HW{1'b0}}, r_w} * {{NW{1'b0}}, r_h};
    end

    // Saturate and fold into the maximum
    always_comb begin
        w_sat  = (64'(r_prod) > 64'(AREA_LIMIT)) ? AREA_LIMIT : AREA_W'(r_prod);
        n_best = r_best;
        if (r_v2 && (w_sat > r_best)) begin
            n_best = w_sat;
        end
    end

    assign o_sts.busy = r_v1 || r_v2;
    assign o_best     = r_best;

endmodule

`default_nettype wire

// ----- src/max_rectangle_histogram_scan.sv -----
// ----------------------------------------------------------------------------
// max_rectangle_histogram_scan
// Largest all-ones rectangle of a binary matrix streamed in row-major order,
// using per-column height and left/right bounds kept in one column store.
//
//   channel  | dir | handshake                  | payload
//   ---------+-----+----------------------------+---------------------------
//   s_axis   | in  | s_axis_tvalid/tready       | tdata[0] cell_bit, tlast last_cell
//   m_axis   | out | m_axis_tvalid/tready       | tdata[16:0] max_area
//   cfg      | in  | i_cfg_we                   | i_cfg_wdata columns_in_use
//
// In the forward pass each cell is a read-modify-write of its column entry,
// back to back. The cell that ends a row then starts a walk back over each
// column of the row in turn, set by the single read port of the store. The
// last cell's walk is followed by the area pipeline drain before the word is
// loaded. Reset and each report clear the store valid bits.
// A stalled result word holds the next report in the drain, and the input waits.
// ----------------------------------------------------------------------------
`default_nettype none

module max_rectangle_histogram_scan #(
    parameter int unsigned MAX_COLS = 256,
    parameter int unsigned MAX_ROWS = 256
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // configuration
    input  wire                                i_cfg_we,
    input  wire  [mrh_pkg::CFG_W-1:0]          i_cfg_wdata,   // columns_in_use
    // input words
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [mrh_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] cell_bit
    input  wire                                s_axis_tlast,  // last_cell
    // result words
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [mrh_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // [16:0] max_area
);
    import mrh_pkg::*;

    localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned NW = $clog2(MAX_COLS + 1);
    localparam int unsigned HW = $clog2(MAX_ROWS + 1);
    localparam int unsigned DW = 1 + HW + 2 * NW;
    // word layout: cell | height | left | right
    localparam int unsigned H_LO = 1;
    localparam int unsigned L_LO = 1 + HW;
    localparam int unsigned R_LO = 1 + HW + NW;
    localparam int unsigned RST_COLS = (CFG_RESET > MAX_COLS) ? MAX_COLS : CFG_RESET;

    // registers
    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [AW-1:0]     r_ci, n_ci;
    logic [NW-1:0]     r_rl, n_rl;
    logic [AW-1:0]     r_j, n_j;
    logic              r_bit, n_bit;
    logic              r_last, n_last;
    logic              r_row_end, n_row_end;
    logic [AW-1:0]     r_k, n_k;
    logic [NW-1:0]     r_cur_right, n_cur_right;
    logic [NW-1:0]     r_clr_n, n_clr_n;
    logic              r_out_valid, n_out_valid;
    logic [AREA_W-1:0] r_out_data, n_out_data;

    // datapath nets
    logic [NW-1:0]     w_n;
    logic [31:0]       w_cfg_ext;
    logic              w_acc;
    logic [AW-1:0]     w_j_new;
    logic              w_row_end_new;
    logic              w_out_free;
    logic              w_fin;

    logic [DW-1:0]     w_rd_data;
    logic              w_rd_valid;
    logic              w_cell;
    logic [HW-1:0]     w_h;
    logic [NW-1:0]     w_left;
    logic [NW-1:0]     w_right;

    logic [HW-1:0]     w_h_upd;
    logic [NW-1:0]     w_left_upd;
    logic [DW-1:0]     w_upd_word;
    logic [NW-1:0]     w_right_new;
    logic [NW-1:0]     w_cur_next;
    logic [DW-1:0]     w_walk_word;
    logic [NW-1:0]     w_width;

    t_mem_ctl          w_mem_ctl;
    logic [AW-1:0]     w_wr_addr;
    logic [DW-1:0]     w_wr_data;
    logic [AW-1:0]     w_rd_addr;
    t_area_ctl         w_area_ctl;
    t_area_sts         w_area_sts;
    logic [AREA_W-1:0] w_best;

    // Column count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_W'(CFG_RESET);
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // Clamp the column count into 1..MAX_COLS
    always_comb begin
        w_cfg_ext = 32'(r_cfg);
        if (r_cfg == '0) begin
            w_n = NW'(1);
        end else if (w_cfg_ext > MAX_COLS) begin
            w_n = NW'(MAX_COLS);
        end else begin
            w_n = NW'(w_cfg_ext);
        end
    end

    // Column of the incoming cell and whether it ends the row
    always_comb begin
        if (32'(r_ci) + 32'd1 >= 32'(w_n)) begin
            w_j_new = AW'(32'(w_n) - 32'd1);
        end else begin
            w_j_new = r_ci;
        end
        w_row_end_new = (32'(w_j_new) + 32'd1 >= 32'(w_n)) || s_axis_tlast;
    end

    assign w_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_fin      = !w_area_sts.busy && w_out_free;

    // Unwritten entries read as cleared: zero height and left, right at the
    // column count in force when the store was cleared
    always_comb begin
        w_cell  = w_rd_valid && w_rd_data[0];
        w_h     = w_rd_valid ? w_rd_data[H_LO +: HW] : '0;
        w_left  = w_rd_valid ? w_rd_data[L_LO +: NW] : '0;
        w_right = w_rd_valid ? w_rd_data[R_LO +: NW] : r_clr_n;
    end

    // Forward pass: height and left bound of one column
    always_comb begin
        if (r_bit) begin
            w_h_upd    = (32'(w_h) < MAX_ROWS) ? HW'(32'(w_h) + 32'd1) : w_h;
            w_left_upd = (r_rl > w_left) ? r_rl : w_left;
        end else begin
            w_h_upd    = '0;
            w_left_upd = '0;
        end
        w_upd_word = {w_right, w_left_upd, w_h_upd, r_bit};
    end

    // Backward walk: right bound and area width of one column
    always_comb begin
        if (w_cell) begin
            w_right_new = (r_cur_right < w_right) ? r_cur_right : w_right;
            w_cur_next  = r_cur_right;
        end else begin
            w_right_new = w_n;
            w_cur_next  = NW'(r_k);
        end
        w_width     = (w_right_new > w_left) ? (w_right_new - w_left) : '0;
        w_walk_word = {w_right_new, w_left, w_h, w_cell};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc) n_state = S_UPD;
            end
            S_UPD: begin
                if (w_acc) begin
                    n_state = S_UPD;
                end else if (r_row_end) begin
                    n_state = S_WALK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (r_k == '0) n_state = r_last ? S_DRAIN : S_IDLE;
            end
            S_DRAIN: begin
                if (w_fin) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready    = 1'b0;
        w_mem_ctl.wr_en  = 1'b0;
        w_mem_ctl.clear  = 1'b0;
        w_wr_addr        = r_k;
        w_wr_data        = w_walk_word;
        w_rd_addr        = w_j_new;
        w_area_ctl.cand  = 1'b0;
        w_area_ctl.clear = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_UPD: begin
                s_axis_tready   = !r_row_end;
                w_mem_ctl.wr_en = 1'b1;
                w_wr_addr       = r_j;
                w_wr_data       = w_upd_word;
                if (r_row_end) w_rd_addr = r_j;
            end
            S_WALK: begin
                w_mem_ctl.wr_en = 1'b1;
                w_area_ctl.cand = 1'b1;
                if (r_k != '0) w_rd_addr = r_k - AW'(1);
            end
            S_DRAIN: begin
                w_mem_ctl.clear  = w_fin;
                w_area_ctl.clear = w_fin;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Register next values
    always_comb begin
        n_ci        = r_ci;
        n_rl        = r_rl;
        n_j         = r_j;
        n_bit       = r_bit;
        n_last      = r_last;
        n_row_end   = r_row_end;
        n_k         = r_k;
        n_cur_right = r_cur_right;
        n_clr_n     = r_clr_n;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !m_axis_tready;

        // capture an accepted cell and advance the column counter
        if (w_acc) begin
            n_j       = w_j_new;
            n_bit     = s_axis_tdata[0];
            n_last    = s_axis_tlast;
            n_row_end = w_row_end_new;
            n_ci      = w_row_end_new ? '0 : AW'(32'(w_j_new) + 32'd1);
        end

        // track the run start; arm the walk at the end of the row
        if (r_state == S_UPD) begin
            if (r_row_end) begin
                n_rl        = '0;
                n_k         = r_j;
                n_cur_right = NW'(32'(r_j) + 32'd1);
            end else if (!r_bit) begin
                n_rl = NW'(32'(r_j) + 32'd1);
            end
        end

        // step the walk down the row
        if (r_state == S_WALK) begin
            n_cur_right = w_cur_next;
            if (r_k != '0) n_k = r_k - AW'(1);
        end

        // load the result and restart the matrix
        if ((r_state == S_DRAIN) && w_fin) begin
            n_out_data  = w_best;
            n_out_valid = 1'b1;
            n_clr_n     = w_n;
            n_ci        = '0;
            n_rl        = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ci        <= '0;
            r_rl        <= '0;
            r_last      <= 1'b0;
            r_row_end   <= 1'b0;
            r_clr_n     <= NW'(RST_COLS);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ci        <= n_ci;
            r_rl        <= n_rl;
            r_last      <= n_last;
            r_row_end   <= n_row_end;
            r_clr_n     <= n_clr_n;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_j         <= n_j;
        r_bit       <= n_bit;
        r_k         <= n_k;
        r_cur_right <= n_cur_right;
        r_out_data  <= n_out_data;
    end

    mrh_col_mem #(
        .DEPTH (MAX_COLS),
        .AW    (AW),
        .DW    (DW)
    ) u_col_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mem_ctl),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data),
        .i_rd_addr  (w_rd_addr),
        .o_rd_data  (w_rd_data),
        .o_rd_valid (w_rd_valid)
    );

    mrh_area_unit #(
        .NW (NW),
        .HW (HW)
    ) u_area (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_area_ctl),
        .i_width  (w_width),
        .i_height (w_h),
        .o_sts    (w_area_sts),
        .o_best   (w_best)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - AREA_W){1'b0}}, r_out_data};

endmodule

`default_nettype wire

// ----- src/mrh_checker.sv -----
// ----------------------------------------------------------------------------
// mrh_checker
// Port-level checks of the histogram scan, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mrh_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             s_axis_tvalid,
    input wire                             s_axis_tready,
    input wire                             s_axis_tlast,
    input wire                             m_axis_tvalid,
    input wire                             m_axis_tready,
    input wire [mrh_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import mrh_pkg::*;

    // A result word stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result word dropped before it was taken");

    // A stalled result word keeps its data
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // The last cell ends a row, so the row-end update holds off input next cycle
    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken right after the last cell");

    // A new result word only comes out of the drain, with input held off
    a_out_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result word raised while input was open");

endmodule

bind max_rectangle_histogram_scan mrh_checker u_mrh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
